/* design/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, switched off during reset.
`define PITB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds whenever a qualifying strobe is present.
`define PITB_ASSERT_ON(lbl, cond, prop, msg) \
  `PITB_ASSERT(lbl, (cond) |-> (prop), msg)

`endif

/* design/pitb_pkg.sv */
// Package for the rotated box tester: widths, codes, record types and the CORDIC angle table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pitb_pkg;

  localparam int MAX_BOXES     = 64;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int COORD_W       = 24;
  localparam int SIZE_W        = COORD_W - 1;
  localparam int TRIG_W        = 17;
  localparam int CORDIC_STEPS  = 18;
  localparam int STEP_W        = 5;
  localparam int CORDIC_W      = 34;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic REG_BOX_COUNT = 1'b0;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                         valid;
    logic signed [CORDIC_W-1:0]   x;
    logic signed [CORDIC_W-1:0]   y;
    logic signed [CORDIC_W-1:0]   z;
    logic [1:0]                   quad;
  } cordic_stage_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [SIZE_W-1:0]         dz;
    logic [SIZE_W-1:0]         dx;
    logic [SIZE_W-1:0]         dy;
    logic signed [TRIG_W-1:0]  cos_v;
    logic signed [TRIG_W-1:0]  sin_v;
  } box_entry_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] box;
    logic             last;
  } pipe_ctl_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [CORDIC_W-1:0] atan_turn(logic [STEP_W-1:0] step);
    logic signed [CORDIC_W-1:0] t;
    case (step)
      5'd0:    t = 34'sd536870912;
      5'd1:    t = 34'sd316933406;
      5'd2:    t = 34'sd167458907;
      5'd3:    t = 34'sd85004756;
      5'd4:    t = 34'sd42667331;
      5'd5:    t = 34'sd21354465;
      5'd6:    t = 34'sd10679838;
      5'd7:    t = 34'sd5340245;
      5'd8:    t = 34'sd2670163;
      5'd9:    t = 34'sd1335087;
      5'd10:   t = 34'sd667544;
      5'd11:   t = 34'sd333772;
      5'd12:   t = 34'sd166886;
      5'd13:   t = 34'sd83443;
      5'd14:   t = 34'sd41722;
      5'd15:   t = 34'sd20861;
      5'd16:   t = 34'sd10430;
      5'd17:   t = 34'sd5215;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

/* design/pitb_cordic_cell.sv */
// One CORDIC rotation cell: a single micro-rotation, registered, passed to the next cell.
// Depends on pitb_pkg for the stage record and the angle table.
`timescale 1ns / 1ps

module pitb_cordic_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [pitb_pkg::STEP_W-1:0] step,
  input  pitb_pkg::cordic_stage_t  stage_in,
  output pitb_pkg::cordic_stage_t  stage_out
);
  import pitb_pkg::*;

  cordic_stage_t stage_r, stage_nxt;
  logic signed [CORDIC_W-1:0] xs, ys, at;

  always_comb begin
    xs = stage_in.y >>> step;
    ys = stage_in.x >>> step;
    at = atan_turn(step);
    stage_nxt = stage_in;
    if (!stage_in.z[CORDIC_W-1]) begin
      stage_nxt.x = stage_in.x - xs;
      stage_nxt.y = stage_in.y + ys;
      stage_nxt.z = stage_in.z - at;
    end else begin
      stage_nxt.x = stage_in.x + xs;
      stage_nxt.y = stage_in.y - ys;
      stage_nxt.z = stage_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_in.valid;
    end
    stage_r.x    <= stage_nxt.x;
    stage_r.y    <= stage_nxt.y;
    stage_r.z    <= stage_nxt.z;
    stage_r.quad <= stage_nxt.quad;
  end

  assign stage_out = stage_r;

endmodule

/* design/pitb_cordic.sv */
// Row of CORDIC cells giving cosine and sine of minus a heading in signed Q1.16.
// Depends on pitb_pkg and pitb_cordic_cell.
`timescale 1ns / 1ps

module pitb_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [15:0]                       heading,
  output logic                              out_valid,
  output logic signed [pitb_pkg::TRIG_W-1:0] cos_q,
  output logic signed [pitb_pkg::TRIG_W-1:0] sin_q
);
  import pitb_pkg::*;

  cordic_stage_t chain [0:CORDIC_STEPS];
  logic [15:0] angle;

  function automatic logic signed [TRIG_W-1:0] to_q16(logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W:0] r;
    r = ($signed({v[CORDIC_W-1], v}) + 35'sd8192) >>> 14;
    if (r > 35'sd65535) begin
      return 17'sd65535;
    end else if (r < -35'sd65536) begin
      return -17'sd65536;
    end
    return r[TRIG_W-1:0];
  endfunction

  assign angle = 16'(17'h10000 - {1'b0, heading});

  always_comb begin
    chain[0].valid = in_valid;
    chain[0].x     = CORDIC_X0;
    chain[0].y     = '0;
    chain[0].z     = CORDIC_W'({angle[13:0], 16'b0});
    chain[0].quad  = angle[15:14];
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    pitb_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (STEP_W'(g)),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  always_comb begin
    case (chain[CORDIC_STEPS].quad)
      2'd0: begin
        cos_q = to_q16(chain[CORDIC_STEPS].x);
        sin_q = to_q16(chain[CORDIC_STEPS].y);
      end
      2'd1: begin
        cos_q = to_q16(-chain[CORDIC_STEPS].y);
        sin_q = to_q16(chain[CORDIC_STEPS].x);
      end
      2'd2: begin
        cos_q = to_q16(-chain[CORDIC_STEPS].x);
        sin_q = to_q16(-chain[CORDIC_STEPS].y);
      end
      default: begin
        cos_q = to_q16(chain[CORDIC_STEPS].y);
        sin_q = to_q16(-chain[CORDIC_STEPS].x);
      end
    endcase
  end

  assign out_valid = chain[CORDIC_STEPS].valid;

endmodule

/* design/points_in_rotated_box_test_unit.sv */
// Top level of the rotated box tester: box table, command sequencer and test pipeline.
// Depends on pitb_pkg and pitb_cordic.
`timescale 1ns / 1ps

// A load command (in_cmd 0) stores one box and keeps busy high while the row of 18
// CORDIC cells turns its heading into cosine and sine. A point command (in_cmd 1) is
// tested against boxes 0 .. n-1, n = min(box_count, 64), one box per cycle from the
// single read port of the box table; the results leave on consecutive cycles through
// the table read, offset, product, rotation and test registers, and busy stays high
// until the last result has left. A result is held for one cycle only and cannot be
// stalled. Testing a point against a never-loaded box gives an undefined inside_res.
module points_in_rotated_box_test_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_cmd,
  input  logic [pitb_pkg::IDX_W-1:0]              in_box_index,
  input  logic signed [pitb_pkg::COORD_W-1:0]     in_pos_x,
  input  logic signed [pitb_pkg::COORD_W-1:0]     in_pos_y,
  input  logic signed [pitb_pkg::COORD_W-1:0]     in_pos_z,
  input  logic [pitb_pkg::SIZE_W-1:0]             in_size_x,
  input  logic [pitb_pkg::SIZE_W-1:0]             in_size_y,
  input  logic [pitb_pkg::SIZE_W-1:0]             in_size_z,
  input  logic [15:0]                             in_heading,
  output logic                                    out_strobe,
  output logic [pitb_pkg::IDX_W-1:0]              out_result_box,
  output logic                                    out_inside_res,
  output logic                                    out_last,
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [pitb_pkg::CFG_ADDR_W-1:0]         cfg_paddr,
  input  logic [pitb_pkg::CFG_DATA_W-1:0]         cfg_pwdata,
  output logic [pitb_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                    cfg_pready
);
  import pitb_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] box_count_r;
  logic [CNT_W-1:0] n_r, k_r, n_eff;
  logic accept, issue, cfg_wr, cordic_valid, pipe_empty;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  box_entry_t box_mem [0:MAX_BOXES-1];
  box_entry_t load_r, rd_r;
  logic [IDX_W-1:0] load_idx_r;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;

  pipe_ctl_t ctl0_r, ctl1_r, ctl2_r, ctl3_r;
  logic signed [COORD_W:0]   sx_r, sy_r;
  logic signed [COORD_W+2:0] tz_r;
  logic [SIZE_W-1:0] dz1_r, dx1_r, dy1_r, dx2_r, dy2_r, dx3_r, dy3_r;
  logic signed [TRIG_W-1:0] c1_r, s1_r;
  logic signed [COORD_W+TRIG_W:0] m_xc_r, m_ys_r, m_xs_r, m_yc_r;
  logic zin2_r, zin3_r;
  logic signed [COORD_W+TRIG_W+1:0] lx_r, ly_r;
  logic [COORD_W+TRIG_W+1:0] abs_lx, abs_ly;
  logic signed [COORD_W+1:0] dpz;
  logic [COORD_W+2:0] abs_tz;
  logic out_strobe_r, out_inside_r, out_last_r;
  logic [IDX_W-1:0] out_box_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign n_eff  = (box_count_r > CNT_W'(MAX_BOXES)) ? CNT_W'(MAX_BOXES) : box_count_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BOX_COUNT) ?
                      CFG_DATA_W'(box_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_count_r <= CNT_W'(1);
    end else if (cfg_wr && cfg_paddr[2] == REG_BOX_COUNT) begin
      box_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  pitb_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept && in_cmd == CMD_LOAD),
    .heading   (in_heading),
    .out_valid (cordic_valid),
    .cos_q     (cos_q),
    .sin_q     (sin_q)
  );

  assign pipe_empty = !ctl0_r.valid && !ctl1_r.valid && !ctl2_r.valid &&
                      !ctl3_r.valid && !out_strobe_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_LOAD) begin
            state_nxt = ST_LOAD;
          end else if (n_eff == '0) begin
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_LOAD: begin
        if (cordic_valid) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        if (k_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    issue = 1'b0;
    unique case (state_r)
      ST_ISSUE: issue = 1'b1;
      default:  issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        k_r <= '0;
        n_r <= n_eff;
      end else if (issue) begin
        k_r <= k_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      load_idx_r   <= in_box_index;
      load_r.cx    <= in_pos_x;
      load_r.cy    <= in_pos_y;
      load_r.cz    <= in_pos_z;
      load_r.dx    <= in_size_x;
      load_r.dy    <= in_size_y;
      load_r.dz    <= in_size_z;
      px_r         <= in_pos_x;
      py_r         <= in_pos_y;
      pz_r         <= in_pos_z;
    end
  end

  // Box table: written when the rotation of a load is ready, read once per tested box.
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && cordic_valid) begin
      box_mem[load_idx_r] <= '{cx: load_r.cx, cy: load_r.cy, cz: load_r.cz,
                               dz: load_r.dz, dx: load_r.dx, dy: load_r.dy,
                               cos_v: cos_q, sin_v: sin_q};
    end
    if (issue) begin
      rd_r <= box_mem[k_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r       <= '0;
      ctl1_r       <= '0;
      ctl2_r       <= '0;
      ctl3_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      ctl0_r       <= '{valid: issue, box: k_r[IDX_W-1:0],
                        last: (k_r == n_r - CNT_W'(1))};
      ctl1_r       <= ctl0_r;
      ctl2_r       <= ctl1_r;
      ctl3_r       <= ctl2_r;
      out_strobe_r <= ctl3_r.valid;
    end
  end

  assign dpz = (COORD_W+1)'(pz_r) - (COORD_W+1)'(rd_r.cz);

  // Offsets from the box center, and the vertical test term 2(pz - cz) - dz.
  always_ff @(posedge clk) begin
    sx_r  <= (COORD_W+1)'(px_r) - (COORD_W+1)'(rd_r.cx);
    sy_r  <= (COORD_W+1)'(py_r) - (COORD_W+1)'(rd_r.cy);
    tz_r  <= ((COORD_W+3)'(dpz) <<< 1) - (COORD_W+3)'($signed({1'b0, rd_r.dz}));
    dz1_r <= rd_r.dz;
    dx1_r <= rd_r.dx;
    dy1_r <= rd_r.dy;
    c1_r  <= rd_r.cos_v;
    s1_r  <= rd_r.sin_v;
  end

  assign abs_tz = tz_r[COORD_W+2] ? (COORD_W+3)'(-tz_r) : (COORD_W+3)'(tz_r);

  always_ff @(posedge clk) begin
    m_xc_r <= sx_r * c1_r;
    m_ys_r <= sy_r * s1_r;
    m_xs_r <= sx_r * s1_r;
    m_yc_r <= sy_r * c1_r;
    zin2_r <= abs_tz <= (COORD_W+3)'(dz1_r);
    dx2_r  <= dx1_r;
    dy2_r  <= dy1_r;
  end

  always_ff @(posedge clk) begin
    lx_r   <= (COORD_W+TRIG_W+2)'(m_xc_r) - (COORD_W+TRIG_W+2)'(m_ys_r);
    ly_r   <= (COORD_W+TRIG_W+2)'(m_xs_r) + (COORD_W+TRIG_W+2)'(m_yc_r);
    zin3_r <= zin2_r;
    dx3_r  <= dx2_r;
    dy3_r  <= dy2_r;
  end

  assign abs_lx = lx_r[COORD_W+TRIG_W+1] ? (COORD_W+TRIG_W+2)'(-lx_r) :
                                           (COORD_W+TRIG_W+2)'(lx_r);
  assign abs_ly = ly_r[COORD_W+TRIG_W+1] ? (COORD_W+TRIG_W+2)'(-ly_r) :
                                           (COORD_W+TRIG_W+2)'(ly_r);

  // Half-size tests in the Q.16 scale of the rotated offsets.
  always_ff @(posedge clk) begin
    out_box_r    <= ctl3_r.box;
    out_last_r   <= ctl3_r.last;
    out_inside_r <= zin3_r &&
                    ({abs_lx, 1'b0} < (COORD_W+TRIG_W+3)'({dx3_r, 16'b0})) &&
                    ({abs_ly, 1'b0} < (COORD_W+TRIG_W+3)'({dy3_r, 16'b0}));
  end

  assign out_strobe     = out_strobe_r;
  assign out_result_box = out_box_r;
  assign out_inside_res = out_inside_r;
  assign out_last       = out_last_r;

endmodule

/* design/pitb_checker.sv */
// Port-level checks for the rotated box tester, bound to the top level.
// Depends on pitb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pitb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input logic [pitb_pkg::IDX_W-1:0] out_result_box,
  input logic                       out_last
);
  import pitb_pkg::*;

  // Results only appear while a point is being worked on.
  `PITB_ASSERT_ON(a_strobe_busy, out_strobe, busy, "result outside a busy window")
  // No result follows directly after a command transfer.
  `PITB_ASSERT(a_no_early, (start && !busy) |=> !out_strobe, "result right after transfer")
  // Results of one point come back to back with rising box index.
  `PITB_ASSERT(a_run, (out_strobe && !out_last) |=> (out_strobe &&
    out_result_box == $past(out_result_box) + IDX_W'(1)), "gap or skip in a result run")
  // The final result ends the run.
  `PITB_ASSERT(a_last_ends, (out_strobe && out_last) |=> !out_strobe, "result after last")

endmodule

bind points_in_rotated_box_test_unit pitb_checker u_pitb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_result_box (out_result_box),
  .out_last       (out_last)
);
